@@ rtl/vfc_pkg.sv @@
`timescale 1ns / 1ps
// vfc_pkg: shared constants, control/status types and the sequencer microcode ROM
// for the voxel face culler. No dependencies.
package vfc_pkg;

    localparam int CHUNK_SIDE_DEF = 64;
    localparam int CODE_BITS_DEF  = 3;

    localparam int COORD_W    = 6;
    localparam int DIR_W      = 3;
    localparam int CODE_IN_W  = 3;
    localparam int NUM_DIRS   = 6;
    localparam int CFG_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CMD_W      = 2;
    localparam int QUAD_W     = 21;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    localparam logic [QUAD_W-1:0] QUAD_LIMIT = 21'd1572863;

    localparam logic [CMD_W-1:0] CMD_WR_VOXEL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_BOUND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXAMINE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESTART  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WATER_CODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_MASK = 2'd2;

    localparam logic [CODE_IN_W-1:0] EMPTY_CODE_RST = 3'd0;
    localparam logic [CODE_IN_W-1:0] WATER_CODE_RST = 3'd4;
    localparam logic [NUM_DIRS-1:0]  NMASK_RST      = 6'd0;

    localparam logic [DIR_W-1:0] DIR_PX = 3'd0;
    localparam logic [DIR_W-1:0] DIR_NX = 3'd1;
    localparam logic [DIR_W-1:0] DIR_PY = 3'd2;
    localparam logic [DIR_W-1:0] DIR_NY = 3'd3;
    localparam logic [DIR_W-1:0] DIR_PZ = 3'd4;
    localparam logic [DIR_W-1:0] DIR_NZ = 3'd5;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    // microprogram addresses
    localparam pc_t UPC_CLEAR    = 4'd0;
    localparam pc_t UPC_WAIT     = 4'd1;
    localparam pc_t UPC_EXEC     = 4'd2;
    localparam pc_t UPC_CHECK    = 4'd3;
    localparam pc_t UPC_EV_PX    = 4'd4;
    localparam pc_t UPC_EV_NX    = 4'd5;
    localparam pc_t UPC_EV_PY    = 4'd6;
    localparam pc_t UPC_EV_NY    = 4'd7;
    localparam pc_t UPC_EV_PZ    = 4'd8;
    localparam pc_t UPC_EV_NZ    = 4'd9;
    localparam pc_t UPC_EMIT_PX  = 4'd10;
    localparam pc_t UPC_EMIT_NX  = 4'd11;
    localparam pc_t UPC_EMIT_PY  = 4'd12;
    localparam pc_t UPC_EMIT_NY  = 4'd13;
    localparam pc_t UPC_EMIT_PZ  = 4'd14;
    localparam pc_t UPC_EMIT_NZ  = 4'd15;

    typedef enum logic [1:0] {
        CND_NONE        = 2'd0,
        CND_ALWAYS      = 2'd1,
        CND_NOT_EXAMINE = 2'd2,
        CND_SKIP        = 2'd3
    } cond_t;

    typedef struct packed {
        logic             wait_in;      // take an input word
        logic             clear;        // clearing write at sweep counter
        logic             exec_cmd;     // perform write / restart commands
        logic             rd_en;        // issue store reads
        logic             rd_center;    // read the item voxel, not a neighbor
        logic             latch_center; // capture center code, clear face mask
        logic [DIR_W-1:0] dir;          // read / emit direction
        logic             ev_en;        // judge one face
        logic [DIR_W-1:0] ev_dir;
        logic             emit;         // send face dir if visible
        cond_t            cond;
        pc_t              target;
    } uword_t;

    typedef struct packed {
        logic in_accept;
        logic emit_wait;
        logic clear_done;
        logic not_examine;
        logic skip;
    } ustat_t;

    function automatic uword_t ucode(input pc_t pc);
        uword_t w;
        w        = '0;
        w.cond   = CND_NONE;
        w.target = UPC_WAIT;
        case (pc)
            UPC_CLEAR: w.clear = 1'b1;
            UPC_WAIT:  w.wait_in = 1'b1;
            UPC_EXEC:
            begin
                w.exec_cmd  = 1'b1;
                w.rd_en     = 1'b1;
                w.rd_center = 1'b1;
                w.cond      = CND_NOT_EXAMINE;
            end
            UPC_CHECK:
            begin
                w.latch_center = 1'b1;
                w.rd_en        = 1'b1;
                w.dir          = DIR_PX;
                w.cond         = CND_SKIP;
            end
            UPC_EV_PX:
            begin
                w.rd_en  = 1'b1;
                w.dir    = DIR_NX;
                w.ev_en  = 1'b1;
                w.ev_dir = DIR_PX;
            end
            UPC_EV_NX:
            begin
                w.rd_en  = 1'b1;
                w.dir    = DIR_PY;
                w.ev_en  = 1'b1;
                w.ev_dir = DIR_NX;
            end
            UPC_EV_PY:
            begin
                w.rd_en  = 1'b1;
                w.dir    = DIR_NY;
                w.ev_en  = 1'b1;
                w.ev_dir = DIR_PY;
            end
            UPC_EV_NY:
            begin
                w.rd_en  = 1'b1;
                w.dir    = DIR_PZ;
                w.ev_en  = 1'b1;
                w.ev_dir = DIR_NY;
            end
            UPC_EV_PZ:
            begin
                w.rd_en  = 1'b1;
                w.dir    = DIR_NZ;
                w.ev_en  = 1'b1;
                w.ev_dir = DIR_PZ;
            end
            UPC_EV_NZ:
            begin
                w.ev_en  = 1'b1;
                w.ev_dir = DIR_NZ;
            end
            UPC_EMIT_PX:
            begin
                w.emit = 1'b1;
                w.dir  = DIR_PX;
            end
            UPC_EMIT_NX:
            begin
                w.emit = 1'b1;
                w.dir  = DIR_NX;
            end
            UPC_EMIT_PY:
            begin
                w.emit = 1'b1;
                w.dir  = DIR_PY;
            end
            UPC_EMIT_NY:
            begin
                w.emit = 1'b1;
                w.dir  = DIR_NY;
            end
            UPC_EMIT_PZ:
            begin
                w.emit = 1'b1;
                w.dir  = DIR_PZ;
            end
            UPC_EMIT_NZ:
            begin
                w.emit = 1'b1;
                w.dir  = DIR_NZ;
                w.cond = CND_ALWAYS;
            end
            default: w.cond = CND_NONE;
        endcase
        return w;
    endfunction

endpackage

@@ rtl/vfc_ram.sv @@
`timescale 1ns / 1ps
// vfc_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module vfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/vfc_useq.sv @@
`timescale 1ns / 1ps
// vfc_useq: microprogram sequencer - step counter, control ROM lookup, holds and jumps.
// Depends on vfc_pkg.
module vfc_useq
    import vfc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  ustat_t stat,
    output uword_t ctrl
);

    pc_t   pc_reg;
    pc_t   pc_next;
    logic  hold;
    logic  taken;

    assign ctrl = ucode(pc_reg);

    // stall the step while waiting on input, output slot or the clear sweep
    assign hold = (ctrl.wait_in && !stat.in_accept) || stat.emit_wait ||
                  (ctrl.clear && !stat.clear_done);

    always_comb
    begin
        case (ctrl.cond)
            CND_NONE:        taken = 1'b0;
            CND_ALWAYS:      taken = 1'b1;
            CND_NOT_EXAMINE: taken = stat.not_examine;
            CND_SKIP:        taken = stat.skip;
            default:         taken = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hold)
        begin
            pc_next = pc_reg;
        end
        else if (taken)
        begin
            pc_next = ctrl.target;
        end
        else
        begin
            pc_next = pc_reg + pc_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= UPC_CLEAR;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

@@ rtl/vfc_datapath.sv @@
`timescale 1ns / 1ps
// vfc_datapath: item and config registers, voxel/boundary stores, address generation,
// face visibility, quad counters and output register. Depends on vfc_pkg, vfc_ram.
module vfc_datapath
    import vfc_pkg::*;
#(
    parameter int CHUNK_SIDE = CHUNK_SIDE_DEF,
    parameter int CODE_BITS  = CODE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  uword_t                ctrl,
    output ustat_t                stat,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [CMD_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int SS      = CHUNK_SIDE * CHUNK_SIDE;
    localparam int VOXELS  = SS * CHUNK_SIDE;
    localparam int PLANES  = NUM_DIRS * SS;
    localparam int CLR_N   = (VOXELS > PLANES) ? VOXELS : PLANES;
    localparam int VOX_AW  = $clog2(VOXELS);
    localparam int BND_AW  = $clog2(PLANES);
    localparam int CLR_W   = $clog2(CLR_N);
    localparam int SIDE_W  = $clog2(CHUNK_SIDE + 1);
    localparam int CMP_W   = ((SIDE_W > COORD_W) ? SIDE_W : COORD_W) + 1;
    localparam int CW      = (CODE_BITS > CODE_IN_W) ? CODE_BITS : CODE_IN_W;

    // item registers
    logic [CMD_W-1:0]     cmd_reg;
    logic [COORD_W-1:0]   x_reg, y_reg, z_reg;
    logic [DIR_W-1:0]     side_reg;
    logic [CODE_IN_W-1:0] blk_reg;
    logic [CODE_BITS-1:0] center_reg;
    logic [NUM_DIRS-1:0]  vis_reg;

    // config registers
    logic [CODE_IN_W-1:0] empty_code_reg;
    logic [CODE_IN_W-1:0] water_code_reg;
    logic [NUM_DIRS-1:0]  nmask_reg;

    logic [CLR_W-1:0]     clr_cnt_reg;
    logic [QUAD_W-1:0]    opaque_cnt_reg;
    logic [QUAD_W-1:0]    water_cnt_reg;

    // output register
    logic                  out_valid_reg;
    logic [COORD_W-1:0]    out_x_reg, out_y_reg, out_z_reg;
    logic [DIR_W-1:0]      out_side_reg;
    logic [CODE_IN_W-1:0]  out_block_reg;
    logic                  out_water_reg;
    logic [QUAD_W-1:0]     out_quad_reg;
    logic                  out_last_reg;

    logic                  in_accept;
    logic                  in_chunk;
    logic [CMP_W-1:0]      side_e;
    logic [COORD_W-1:0]    nx, ny, nz;
    logic [COORD_W-1:0]    ax, ay, az;
    logic [VOX_AW-1:0]     vox_addr;
    logic [DIR_W-1:0]      bnd_side;
    logic [COORD_W-1:0]    pa, pb;
    logic [BND_AW-1:0]     bnd_addr;

    logic                  vox_we, bnd_we;
    logic [VOX_AW-1:0]     vox_waddr;
    logic [BND_AW-1:0]     bnd_waddr;
    logic [CODE_BITS-1:0]  vox_wdata;
    logic                  bnd_wdata;
    logic [CODE_BITS-1:0]  vox_q;
    logic                  bnd_q;
    logic                  clr_vox, clr_bnd;
    logic                  clear_done;

    logic [CW-1:0]         empty_e, water_e, cen_e, nb_e;
    logic                  is_water;
    logic [COORD_W-1:0]    ev_c;
    logic                  ev_edge;
    logic                  visible;

    logic                  slot_free;
    logic                  emit_vis;
    logic                  emit_load;
    logic [NUM_DIRS-1:0]   later;
    logic                  last;
    logic [QUAD_W-1:0]     sel_cnt;
    logic                  do_exec_wr_vox, do_exec_wr_bnd, do_restart;

    assign s_axis_tready = ctrl.wait_in;
    assign in_accept     = ctrl.wait_in && s_axis_tvalid;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg  <= s_axis_tuser;
            x_reg    <= s_axis_tdata[5:0];
            y_reg    <= s_axis_tdata[11:6];
            z_reg    <= s_axis_tdata[17:12];
            side_reg <= s_axis_tdata[20:18];
            blk_reg  <= s_axis_tdata[23:21];
        end
        if (ctrl.latch_center)
        begin
            center_reg <= vox_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_code_reg <= EMPTY_CODE_RST;
            water_code_reg <= WATER_CODE_RST;
            nmask_reg      <= NMASK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EMPTY_CODE:    empty_code_reg <= cfg_data[CODE_IN_W-1:0];
                REG_WATER_CODE:    water_code_reg <= cfg_data[CODE_IN_W-1:0];
                REG_NEIGHBOR_MASK: nmask_reg      <= cfg_data[NUM_DIRS-1:0];
                default:           ;
            endcase
        end
    end

    assign side_e   = CMP_W'(CHUNK_SIDE);
    assign in_chunk = (CMP_W'(x_reg) < side_e) && (CMP_W'(y_reg) < side_e) &&
                      (CMP_W'(z_reg) < side_e);

    // neighbor coordinates; edge wrap is harmless, edge faces ignore the read
    always_comb
    begin
        nx = x_reg;
        ny = y_reg;
        nz = z_reg;
        case (ctrl.dir)
            DIR_PX:  nx = x_reg + COORD_W'(1);
            DIR_NX:  nx = x_reg - COORD_W'(1);
            DIR_PY:  ny = y_reg + COORD_W'(1);
            DIR_NY:  ny = y_reg - COORD_W'(1);
            DIR_PZ:  nz = z_reg + COORD_W'(1);
            DIR_NZ:  nz = z_reg - COORD_W'(1);
            default: ;
        endcase
    end

    assign ax = ctrl.rd_center ? x_reg : nx;
    assign ay = ctrl.rd_center ? y_reg : ny;
    assign az = ctrl.rd_center ? z_reg : nz;

    assign vox_addr = VOX_AW'(ax) + VOX_AW'(ay) * VOX_AW'(CHUNK_SIDE) +
                      VOX_AW'(az) * VOX_AW'(SS);

    // boundary plane position: +-x use (y,z), +-y use (x,z), +-z use (x,y)
    assign bnd_side = ctrl.exec_cmd ? side_reg : ctrl.dir;
    assign pa       = (bnd_side[2:1] == 2'd0) ? y_reg : x_reg;
    assign pb       = (bnd_side[2:1] == 2'd2) ? y_reg : z_reg;
    assign bnd_addr = BND_AW'(bnd_side) * BND_AW'(SS) +
                      BND_AW'(pa) * BND_AW'(CHUNK_SIDE) + BND_AW'(pb);

    assign do_exec_wr_vox = ctrl.exec_cmd && (cmd_reg == CMD_WR_VOXEL) && in_chunk;
    assign do_exec_wr_bnd = ctrl.exec_cmd && (cmd_reg == CMD_WR_BOUND) && in_chunk &&
                            (side_reg <= DIR_NZ);
    assign do_restart     = ctrl.exec_cmd && (cmd_reg == CMD_RESTART);

    assign clr_vox    = ctrl.clear && ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(VOXELS));
    assign clr_bnd    = ctrl.clear && ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(PLANES));
    assign clear_done = clr_cnt_reg == CLR_W'(CLR_N - 1);

    assign vox_we    = clr_vox || do_exec_wr_vox;
    assign vox_waddr = ctrl.clear ? clr_cnt_reg[VOX_AW-1:0] : vox_addr;
    assign vox_wdata = ctrl.clear ? '0 : CODE_BITS'(blk_reg);
    assign bnd_we    = clr_bnd || do_exec_wr_bnd;
    assign bnd_waddr = ctrl.clear ? clr_cnt_reg[BND_AW-1:0] : bnd_addr;
    assign bnd_wdata = !ctrl.clear &&
                       ((blk_reg == empty_code_reg) || (blk_reg == water_code_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (ctrl.clear && !clear_done)
        begin
            clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
        end
    end

    vfc_ram #(
        .WIDTH (CODE_BITS),
        .DEPTH (VOXELS)
    ) u_vox_ram (
        .clk   (clk),
        .we    (vox_we),
        .waddr (vox_waddr),
        .wdata (vox_wdata),
        .re    (ctrl.rd_en),
        .raddr (vox_addr),
        .rdata (vox_q)
    );

    vfc_ram #(
        .WIDTH (1),
        .DEPTH (PLANES)
    ) u_bnd_ram (
        .clk   (clk),
        .we    (bnd_we),
        .waddr (bnd_waddr),
        .wdata (bnd_wdata),
        .re    (ctrl.rd_en),
        .raddr (bnd_addr),
        .rdata (bnd_q)
    );

    // face judgement
    assign empty_e  = CW'(empty_code_reg);
    assign water_e  = CW'(water_code_reg);
    assign cen_e    = CW'(center_reg);
    assign nb_e     = CW'(vox_q);
    assign is_water = cen_e == water_e;

    always_comb
    begin
        case (ctrl.ev_dir[2:1])
            2'd0:    ev_c = x_reg;
            2'd1:    ev_c = y_reg;
            default: ev_c = z_reg;
        endcase
    end

    assign ev_edge = ctrl.ev_dir[0] ? (ev_c == '0) :
                     ((CMP_W'(ev_c) + CMP_W'(1)) >= side_e);

    always_comb
    begin
        if (is_water)
        begin
            visible = (ctrl.ev_dir == DIR_PY) && !ev_edge && (nb_e == empty_e);
        end
        else if (ev_edge)
        begin
            visible = !nmask_reg[ctrl.ev_dir] || bnd_q;
        end
        else
        begin
            visible = (nb_e == empty_e) || (nb_e == water_e);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vis_reg <= '0;
        end
        else if (ctrl.latch_center)
        begin
            vis_reg <= '0;
        end
        else if (ctrl.ev_en)
        begin
            vis_reg[ctrl.ev_dir] <= visible;
        end
    end

    // emission: last when no later direction is visible
    assign slot_free = !out_valid_reg || m_axis_tready;
    assign emit_vis  = vis_reg[ctrl.dir];
    assign emit_load = ctrl.emit && emit_vis && slot_free;
    assign later     = vis_reg >> ctrl.dir;
    assign last      = ~|later[NUM_DIRS-1:1];
    assign sel_cnt   = is_water ? water_cnt_reg : opaque_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opaque_cnt_reg <= '0;
            water_cnt_reg  <= '0;
        end
        else if (do_restart)
        begin
            opaque_cnt_reg <= '0;
            water_cnt_reg  <= '0;
        end
        else if (emit_load && (sel_cnt < QUAD_LIMIT))
        begin
            if (is_water)
            begin
                water_cnt_reg <= water_cnt_reg + QUAD_W'(1);
            end
            else
            begin
                opaque_cnt_reg <= opaque_cnt_reg + QUAD_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_x_reg     <= x_reg;
            out_y_reg     <= y_reg;
            out_z_reg     <= z_reg;
            out_side_reg  <= ctrl.dir;
            out_block_reg <= cen_e[CODE_IN_W-1:0];
            out_water_reg <= is_water;
            out_quad_reg  <= sel_cnt;
            out_last_reg  <= last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_quad_reg, out_block_reg, out_side_reg,
                            out_z_reg, out_y_reg, out_x_reg};
    assign m_axis_tuser  = out_water_reg;
    assign m_axis_tlast  = out_last_reg;

    assign stat.in_accept   = in_accept;
    assign stat.emit_wait   = ctrl.emit && emit_vis && !slot_free;
    assign stat.clear_done  = clear_done;
    assign stat.not_examine = cmd_reg != CMD_EXAMINE;
    assign stat.skip        = !in_chunk || (nb_e == empty_e);

endmodule

@@ rtl/voxel_face_culler_core.sv @@
`timescale 1ns / 1ps
// voxel_face_culler_core: top level, microcoded sequencer driving the culling datapath.
// Depends on vfc_pkg, vfc_useq, vfc_datapath (and vfc_ram below it).
//
// Usage:
//   s_axis carries commands: write voxel, write boundary entry, examine voxel,
//   restart quad counters. m_axis returns one word per visible face of an
//   examined voxel, in +x,-x,+y,-y,+z,-z order, tlast on the voxel's final face.
//   cfg_we/cfg_index/cfg_data write empty code, water code and neighbor mask.
// Sequencing (one item at a time, set by the 16-step microprogram and the
//   one-read-per-cycle voxel store):
//   write / restart commands: wait and execute steps.
//   examine of an empty or out-of-chunk voxel: wait, execute and check steps.
//   examine of a solid voxel: wait, execute, check, judge and emit steps (center
//   read, six neighbor reads and judgements, six emit slots).
// Reset: both stores are swept to zero, one entry per cycle, over the sweep
//   counter's max(CHUNK_SIDE^3, 6*CHUNK_SIDE^2) addresses (262144 at the default size);
//   s_axis_tready stays low meanwhile, config writes are taken throughout.
// Back-pressure: a face waits in the output register; while it is full and
//   m_axis_tready is low, a visible face's emit step holds; s_axis_tready stays low.
module voxel_face_culler_core
    import vfc_pkg::*;
#(
    parameter int CHUNK_SIDE = CHUNK_SIDE_DEF,
    parameter int CODE_BITS  = CODE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // coord_x, coord_y, coord_z, side, block_code
    input  logic [CMD_W-1:0]      s_axis_tuser,  // command
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // face_x, face_y, face_z, face_side,
                                                 // face_block, quad_number, 3 zero bits
    output logic                  m_axis_tuser,  // translucent
    output logic                  m_axis_tlast,  // last_face
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    uword_t ctrl;
    ustat_t stat;

    vfc_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    vfc_datapath #(
        .CHUNK_SIDE (CHUNK_SIDE),
        .CODE_BITS  (CODE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

endmodule

@@ verif/tb_voxel_face_culler_core.sv @@
`timescale 1ns / 1ps
// tb_voxel_face_culler_core: self-checking bench for the voxel face culler, with a face
// predictor, randomized stream traffic with back-pressure, and config phases.
// Depends on vfc_pkg and the voxel_face_culler_core RTL.
module tb_voxel_face_culler_core;
    import vfc_pkg::*;

    localparam int LIMIT_CYCLES = 1_200_000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int EDGE_MAX     = CHUNK_SIDE_DEF - 1;
    localparam int PLANE_SZ     = CHUNK_SIDE_DEF * CHUNK_SIDE_DEF;
    localparam int VOX_SZ       = PLANE_SZ * CHUNK_SIDE_DEF;
    localparam int PHASE_ITEMS  = 68;

    typedef logic [2:0][COORD_W-1:0] vpos_t;   // [0] x, [1] y, [2] z

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        vpos_t                pos;
        logic [DIR_W-1:0]     side;
        logic [CODE_IN_W-1:0] code;
    } vcmd_t;

    typedef struct packed {
        vpos_t                pos;
        logic [DIR_W-1:0]     side;
        logic [CODE_IN_W-1:0] block;
        logic                 water;
        logic [QUAD_W-1:0]    quad;
        logic                 last;
    } face_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    voxel_face_culler_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // predictor state
    bit [CODE_IN_W-1:0] vox_mem [0:VOX_SZ-1];
    bit                 bnd_open [0:NUM_DIRS*PLANE_SZ-1];
    logic [QUAD_W-1:0]  opaque_cnt = '0;
    logic [QUAD_W-1:0]  water_cnt = '0;
    logic [2:0]         cfg_empty = EMPTY_CODE_RST;
    logic [2:0]         cfg_water = WATER_CODE_RST;
    logic [5:0]         cfg_nmask = NMASK_RST;

    vcmd_t cmd_q[$];
    face_t face_q[$];

    int  err_cnt = 0;
    int  cyc = 0;
    int  queued_cnt = 0;
    int  taken_cnt = 0;
    int  faces_seen = 0;
    int  water_seen = 0;
    int  cfg_sets = 0;
    int  hold_reqs = 0;
    int  hold_seen = 0;
    int  rx_hold = 0;
    int  rx_stall = 0;
    int  tx_gap = 0;
    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;
    logic in_fire_q = 1'b0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int unsigned vox_idx(input vpos_t p);
        return {p[2], p[1], p[0]};
    endfunction

    function automatic int unsigned plane_idx(input int d, input vpos_t p);
        int axis;
        int a;
        int b;
        axis = d >> 1;
        a = (axis == 0) ? p[1] : p[0];
        b = (axis == 2) ? p[1] : p[2];
        return d * PLANE_SZ + a * CHUNK_SIDE_DEF + b;
    endfunction

    function automatic bit face_shows(input vpos_t p, input int d, input bit is_water);
        int axis;
        bit neg;
        vpos_t nb;
        logic [2:0] ncode;
        axis = d >> 1;
        neg  = d[0];
        if ((neg && p[axis] == 0) || (!neg && p[axis] == EDGE_MAX))
        begin
            if (is_water)
                return 1'b0;
            if (!cfg_nmask[d])
                return 1'b1;
            return bnd_open[plane_idx(d, p)];
        end
        nb = p;
        nb[axis] = neg ? p[axis] - COORD_W'(1) : p[axis] + COORD_W'(1);
        ncode = vox_mem[vox_idx(nb)];
        if (ncode == cfg_empty)
            return 1'b1;
        return !is_water && ncode == cfg_water;
    endfunction

    task automatic cull_faces(input vpos_t p);
        face_t faces [0:NUM_DIRS-1];
        logic [2:0] code;
        bit is_water;
        int n;
        n = 0;
        code = vox_mem[vox_idx(p)];
        if (code == cfg_empty)
            return;
        is_water = (code == cfg_water);
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            if (is_water && d != DIR_PY)
                continue;
            if (!face_shows(p, d, is_water))
                continue;
            faces[n].pos   = p;
            faces[n].side  = d[DIR_W-1:0];
            faces[n].block = code;
            faces[n].water = is_water;
            faces[n].last  = 1'b0;
            if (is_water)
            begin
                faces[n].quad = water_cnt;
                if (water_cnt < QUAD_LIMIT)
                    water_cnt = water_cnt + 1'b1;
            end
            else
            begin
                faces[n].quad = opaque_cnt;
                if (opaque_cnt < QUAD_LIMIT)
                    opaque_cnt = opaque_cnt + 1'b1;
            end
            n++;
        end
        if (n > 0)
            faces[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            face_q.insert(face_q.size(), faces[i]);
    endtask

    task automatic apply_cmd(input vcmd_t c);
        case (c.cmd)
            CMD_RESTART:
            begin
                opaque_cnt = '0;
                water_cnt  = '0;
            end
            CMD_WR_BOUND:
                if (c.side < NUM_DIRS)
                    bnd_open[plane_idx(c.side, c.pos)] =
                        (c.code == cfg_empty || c.code == cfg_water);
            CMD_WR_VOXEL:
                vox_mem[vox_idx(c.pos)] = c.code;
            default:
                cull_faces(c.pos);
        endcase
    endtask

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            err_cnt++;
        end
    endtask

    // monitor: face checks and prediction on every accepted command word
    always @(posedge clk)
    begin
        face_t want;
        vcmd_t c;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                faces_seen++;
                if (m_axis_tuser)
                    water_seen++;
                if (face_q.size() == 0)
                begin
                    $error("face word with nothing expected: tdata %h", m_axis_tdata);
                    err_cnt++;
                end
                else
                begin
                    want = face_q.pop_front();
                    check_field("face_x", want.pos[0], m_axis_tdata[5:0]);
                    check_field("face_y", want.pos[1], m_axis_tdata[11:6]);
                    check_field("face_z", want.pos[2], m_axis_tdata[17:12]);
                    check_field("face_side", want.side, m_axis_tdata[20:18]);
                    check_field("face_block", want.block, m_axis_tdata[23:21]);
                    check_field("translucent", want.water, m_axis_tuser);
                    check_field("quad_number", want.quad, m_axis_tdata[44:24]);
                    check_field("last_face", want.last, m_axis_tlast);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                c.cmd    = s_axis_tuser;
                c.pos[0] = s_axis_tdata[5:0];
                c.pos[1] = s_axis_tdata[11:6];
                c.pos[2] = s_axis_tdata[17:12];
                c.side   = s_axis_tdata[20:18];
                c.code   = s_axis_tdata[23:21];
                apply_cmd(c);
                taken_cnt++;
            end
        end
        in_fire_q <= s_axis_tvalid && s_axis_tready;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(1, 2);
        if (r < 92)
            return $urandom_range(3, 8);
        return $urandom_range(15, 35);
    endfunction

    // command driver
    always @(negedge clk)
    begin
        vcmd_t nxt;
        if (!s_axis_tvalid || in_fire_q)
        begin
            if (tx_gap > 0)
            begin
                tx_gap <= tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (cmd_q.size() > 0)
            begin
                nxt = cmd_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {nxt.code, nxt.side, nxt.pos[2], nxt.pos[1], nxt.pos[0]};
                s_axis_tuser  <= nxt.cmd;
                if (tx_idle_en && $urandom_range(0, 99) >= 45)
                    tx_gap <= idle_len();
                else
                    tx_gap <= 0;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // face receiver with random stalls and one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_seen != hold_reqs)
        begin
            hold_seen <= hold_reqs;
            rx_hold <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (rx_stall > 0)
        begin
            rx_stall <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end
        else if (rx_idle_en && $urandom_range(0, 99) < 25)
        begin
            rx_stall <= idle_len() - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d faces outstanding", cyc, face_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic add_cmd(input logic [CMD_W-1:0] cmd, input vpos_t p,
                           input int side, input int code);
        vcmd_t c;
        c.cmd  = cmd;
        c.pos  = p;
        c.side = side[DIR_W-1:0];
        c.code = code[CODE_IN_W-1:0];
        cmd_q.insert(cmd_q.size(), c);
        if (!(cmd == CMD_WR_BOUND && side >= NUM_DIRS))
            queued_cnt++;
    endtask

    function automatic vpos_t at(input int x, input int y, input int z);
        vpos_t p;
        p[0] = x[COORD_W-1:0];
        p[1] = y[COORD_W-1:0];
        p[2] = z[COORD_W-1:0];
        return p;
    endfunction

    function automatic int pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 22)
            return 0;
        if (r < 44)
            return EDGE_MAX;
        if (r < 57)
            return $urandom_range(1, 3);
        if (r < 70)
            return $urandom_range(EDGE_MAX - 3, EDGE_MAX - 1);
        return $urandom_range(0, EDGE_MAX);
    endfunction

    function automatic int pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return cfg_empty;
        if (r < 55)
            return cfg_water;
        return $urandom_range(0, 7);
    endfunction

    // wait for the block to go quiet; writes and restarts leave no face to wait on
    task automatic wait_drain();
        while (cmd_q.size() != 0 || s_axis_tvalid || face_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input int e, input int w, input int m);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_EMPTY_CODE;
        cfg_data  <= e[CFG_W-1:0];
        @(negedge clk);
        cfg_index <= REG_WATER_CODE;
        cfg_data  <= w[CFG_W-1:0];
        @(negedge clk);
        cfg_index <= REG_NEIGHBOR_MASK;
        cfg_data  <= m[CFG_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_empty = e[2:0];
        cfg_water = w[2:0];
        cfg_nmask = m[5:0];
        cfg_sets++;
    endtask

    // mostly build-then-examine clusters around edge-biased spots, some noise
    task automatic gen_phase(input int n_items);
        int stop_at;
        int axis;
        vpos_t ctr;
        vpos_t nb;
        stop_at = queued_cnt + n_items;
        while (queued_cnt < stop_at)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                ctr = at(pick_coord(), pick_coord(), pick_coord());
                nb  = ctr;
                add_cmd(CMD_WR_VOXEL, ctr, $urandom_range(0, 7), pick_code());
                for (int d = 0; d < NUM_DIRS; d++)
                begin
                    if ($urandom_range(0, 99) < 55)
                    begin
                        axis = d >> 1;
                        nb = ctr;
                        if ((d[0] && ctr[axis] == 0) || (!d[0] && ctr[axis] == EDGE_MAX))
                        begin
                            nb[axis] = COORD_W'($urandom_range(0, EDGE_MAX));
                            add_cmd(CMD_WR_BOUND, nb, d, pick_code());
                        end
                        else
                        begin
                            nb[axis] = d[0] ? ctr[axis] - COORD_W'(1) :
                                              ctr[axis] + COORD_W'(1);
                            add_cmd(CMD_WR_VOXEL, nb, $urandom_range(0, 7), pick_code());
                        end
                    end
                end
                add_cmd(CMD_EXAMINE, ctr, $urandom_range(0, 7), $urandom_range(0, 7));
                if ($urandom_range(0, 99) < 30)
                    add_cmd(CMD_EXAMINE, nb, $urandom_range(0, 7), $urandom_range(0, 7));
            end
            else
                add_cmd(CMD_W'($urandom_range(0, 3)), at($urandom, $urandom, $urandom),
                        $urandom_range(0, 7), $urandom_range(0, 7));
        end
    endtask

    initial
    begin
        int e;
        int w;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // written while the stores are still being swept
        set_config(0, 4, 6'b111000);

        add_cmd(CMD_EXAMINE,  at(0, 0, 0), 0, 0);
        add_cmd(CMD_WR_VOXEL, at(0, 0, 0), 0, 1);
        add_cmd(CMD_EXAMINE,  at(0, 0, 0), 0, 0);
        add_cmd(CMD_WR_BOUND, at(0, 63, 0), DIR_NY, 0);
        add_cmd(CMD_EXAMINE,  at(0, 0, 0), 0, 0);
        add_cmd(CMD_WR_BOUND, at(0, 0, 17), DIR_NZ, 4);
        add_cmd(CMD_EXAMINE,  at(0, 0, 0), 0, 0);
        add_cmd(CMD_WR_BOUND, at(0, 0, 0), DIR_NZ, 2);
        add_cmd(CMD_WR_BOUND, at(0, 0, 0), 6, 0);
        add_cmd(CMD_WR_BOUND, at(63, 63, 63), 7, 0);
        add_cmd(CMD_WR_VOXEL, at(1, 0, 0), 0, 4);
        add_cmd(CMD_WR_VOXEL, at(0, 1, 0), 0, 3);
        add_cmd(CMD_EXAMINE,  at(0, 0, 0), 0, 0);
        add_cmd(CMD_EXAMINE,  at(1, 0, 0), 0, 0);
        add_cmd(CMD_WR_VOXEL, at(1, 1, 0), 0, 4);
        add_cmd(CMD_EXAMINE,  at(1, 0, 0), 0, 0);
        add_cmd(CMD_WR_VOXEL, at(10, 63, 10), 0, 4);
        add_cmd(CMD_EXAMINE,  at(10, 63, 10), 0, 0);
        add_cmd(CMD_WR_VOXEL, at(63, 63, 63), 7, 7);
        add_cmd(CMD_EXAMINE,  at(63, 63, 63), 7, 7);
        add_cmd(CMD_RESTART,  at(63, 63, 63), 7, 7);
        add_cmd(CMD_EXAMINE,  at(63, 63, 63), 0, 0);
        add_cmd(CMD_WR_VOXEL, at(63, 63, 63), 0, 0);
        add_cmd(CMD_EXAMINE,  at(63, 63, 63), 0, 0);
        add_cmd(CMD_EXAMINE,  at(1, 1, 0), 0, 0);
        wait_drain();

        set_config(EMPTY_CODE_RST, WATER_CODE_RST, $urandom_range(0, 63));
        gen_phase(PHASE_ITEMS);
        wait_drain();

        // long receiver hold-off while the sender keeps offering
        set_config(7, 0, 63);
        gen_phase(PHASE_ITEMS);
        hold_reqs++;
        wait_drain();

        e = $urandom_range(0, 7);
        w = (e + $urandom_range(1, 7)) % 8;
        set_config(e, w, $urandom_range(0, 63));
        gen_phase(PHASE_ITEMS);
        wait_drain();

        // water code equal to the empty code
        set_config(5, 5, 0);
        gen_phase(PHASE_ITEMS);
        wait_drain();

        // back to back on both sides
        set_config(1, 6, 63);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        gen_phase(PHASE_ITEMS);
        wait_drain();

        $display("%0d commands accepted under %0d register settings", taken_cnt, cfg_sets);
        $display("%0d face words compared, %0d of them translucent", faces_seen, water_seen);
        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/vfc_pkg.sv
rtl/vfc_ram.sv
rtl/vfc_useq.sv
rtl/vfc_datapath.sv
rtl/voxel_face_culler_core.sv
verif/tb_voxel_face_culler_core.sv
